>>> sv/turtle_segment_generator_unit_assert.svh
// Assertion macros for the turtle segment generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TURTLE_SEGMENT_GENERATOR_UNIT_ASSERT_SVH
`define TURTLE_SEGMENT_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TSG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TSG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TSG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TSG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/tsg_pkg.sv
// Package for the turtle segment generator: symbol codes, status codes,
// register indexes, sequencer states and default sizes. No dependencies.
package tsg_pkg;

  localparam int unsigned SegDepthDef   = 1024;
  localparam int unsigned StackDepthDef = 32;

  localparam logic [7:0] SymPush   = 8'h5B;  // [
  localparam logic [7:0] SymPop    = 8'h5D;  // ]
  localparam logic [7:0] SymPlus   = 8'h2B;  // +
  localparam logic [7:0] SymMinus  = 8'h2D;  // -
  localparam logic [7:0] SymAmp    = 8'h26;  // &
  localparam logic [7:0] SymPct    = 8'h25;  // %
  localparam logic [7:0] SymHash   = 8'h23;  // #
  localparam logic [7:0] SymSlash  = 8'h2F;  // /

  localparam logic [2:0] StTurn  = 3'd0;
  localparam logic [2:0] StNew   = 3'd1;
  localparam logic [2:0] StDup   = 3'd2;
  localparam logic [2:0] StFull  = 3'd3;
  localparam logic [2:0] StOver  = 3'd4;
  localparam logic [2:0] StUnder = 3'd5;

  localparam logic [1:0] RegCos  = 2'd0;
  localparam logic [1:0] RegSin  = 2'd1;
  localparam logic [1:0] RegStep = 2'd2;
  localparam logic [1:0] RegMax  = 2'd3;

  localparam logic signed [17:0] OneQ16 = 18'sd65536;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_TURN, S_DRAW, S_SCAN, S_POP_RD, S_POP_LD, S_EMIT
  } tsg_state_e;

endpackage

>>> sv/turtle_segment_generator_unit.sv
// 3-D turtle interpreter: one sentence symbol per input beat, one result beat
// per symbol. A turn runs on one shared 19x18 multiplier at four products per
// matrix row. A draw walks the stored segments in the segment memory to look
// for a duplicate; a duplicate found early ends the walk sooner. A stalled
// output register holds the sequencer until the result can be written. Frame,
// stack level and segment count clear on reset and on a new-sentence beat. The
// stack and segment memories need no clearing, since only written rows are
// ever read. The input side takes a beat only while the sequencer is idle. A
// finished result sits in the output register while the next symbol is
// accepted. Configuration writes are taken at any edge with cfg_we_i high and
// must only occur while the block is idle.
`include "turtle_segment_generator_unit_assert.svh"
module turtle_segment_generator_unit #(
  parameter int unsigned SEG_DEPTH   = tsg_pkg::SegDepthDef,
  parameter int unsigned STACK_DEPTH = tsg_pkg::StackDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] symbol
  input  logic [0:0]   s_axis_tuser,   // [0] new_sentence
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
  output logic [2:0]   m_axis_tuser    // [2:0] status
);

  localparam int unsigned SegAw = $clog2(SEG_DEPTH);
  localparam int unsigned CntW  = SegAw + 1;
  localparam int unsigned StkAw = $clog2(STACK_DEPTH);
  localparam int unsigned LvlW  = StkAw + 1;
  localparam int unsigned CmpW  = (CntW > 11) ? CntW : 11;
  localparam int unsigned SegW  = 192;
  localparam int unsigned StkW  = 9 * 18 + 3 * 32;

  // Configuration registers
  logic signed [17:0] cos_q, sin_q;
  logic [30:0]        step_q;
  logic [10:0]        maxseg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= tsg_pkg::OneQ16;
      sin_q    <= '0;
      step_q   <= 31'd65536;
      maxseg_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsg_pkg::RegCos:  cos_q    <= cfg_data_i[17:0];
        tsg_pkg::RegSin:  sin_q    <= cfg_data_i[17:0];
        tsg_pkg::RegStep: step_q   <= cfg_data_i;
        tsg_pkg::RegMax:  maxseg_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  tsg_pkg::tsg_state_e state_q, state_d;
  logic signed [17:0] orient_q [9];
  logic signed [17:0] orient_d [9];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] pos_d [3];
  logic signed [31:0] segs_q [3];
  logic signed [31:0] segs_d [3];
  logic signed [31:0] sege_q [3];
  logic signed [31:0] sege_d [3];
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [7:0]      sym_q, sym_d;
  logic [3:0]      step_cnt_q, step_cnt_d;  // turn: row*4+phase, draw: row
  logic signed [37:0] acc_q, acc_d;
  logic signed [17:0] va_q, va_d;
  logic [2:0]      res_q, res_d;
  logic            out_vld_q, out_vld_d;
  logic [2:0]      out_st_q, out_st_d;
  logic [191:0]    out_dat_q, out_dat_d;

  // Memories
  logic [SegW-1:0] seg_mem [SEG_DEPTH];
  logic [SegW-1:0] seg_rd_q;
  logic [SegAw-1:0] seg_raddr, seg_waddr;
  logic            seg_we;
  logic [StkW-1:0] stk_mem [STACK_DEPTH];
  logic [StkW-1:0] stk_rd_q, stk_wdata;
  logic [StkAw-1:0] stk_addr;
  logic            stk_we;

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[seg_waddr] <= {sege_q[2], sege_q[1], sege_q[0],
                                       segs_q[2], segs_q[1], segs_q[0]};
    seg_rd_q <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_addr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_addr];
  end

  // Turn operand decode
  logic [1:0] col_a, col_b;
  logic       neg;
  always_comb begin
    col_a = 2'd0; col_b = 2'd1; neg = 1'b0;
    case (sym_q)
      tsg_pkg::SymPlus:  begin col_a = 2'd0; col_b = 2'd1; neg = 1'b0; end
      tsg_pkg::SymMinus: begin col_a = 2'd0; col_b = 2'd1; neg = 1'b1; end
      tsg_pkg::SymAmp:   begin col_a = 2'd2; col_b = 2'd0; neg = 1'b0; end
      tsg_pkg::SymPct:   begin col_a = 2'd2; col_b = 2'd0; neg = 1'b1; end
      tsg_pkg::SymHash:  begin col_a = 2'd1; col_b = 2'd2; neg = 1'b0; end
      tsg_pkg::SymSlash: begin col_a = 2'd1; col_b = 2'd2; neg = 1'b1; end
      default: ;
    endcase
  end

  logic [1:0] row;
  logic [1:0] phase;
  logic [3:0] idx_a, idx_b, idx_y;
  logic signed [18:0] s_eff, mul_x;
  logic signed [17:0] mul_y;
  logic signed [36:0] prod;
  logic signed [37:0] sum;
  logic signed [21:0] rnd;
  logic signed [17:0] sat18;
  logic signed [49:0] dprod;
  logic signed [33:0] drnd;
  logic signed [34:0] dend;
  logic signed [31:0] sat32;

  assign row   = step_cnt_q[3:2];
  assign phase = step_cnt_q[1:0];
  assign idx_a = 4'({2'b00, row} * 4'd3 + {2'b00, col_a});
  assign idx_b = 4'({2'b00, row} * 4'd3 + {2'b00, col_b});
  assign idx_y = 4'({2'b00, step_cnt_q[1:0]} * 4'd3 + 4'd1);
  assign s_eff = neg ? -19'(sin_q) : 19'(sin_q);

  always_comb begin
    case (phase)
      2'd0:    begin mul_x = 19'(cos_q); mul_y = orient_q[idx_a]; end
      2'd1:    begin mul_x = s_eff;      mul_y = orient_q[idx_b]; end
      2'd2:    begin mul_x = 19'(cos_q); mul_y = orient_q[idx_b]; end
      default: begin mul_x = -s_eff;     mul_y = va_q;            end
    endcase
  end

  // Sum of two products, round half up, saturate to Q1.16 range
  assign prod  = mul_x * mul_y;
  assign sum   = acc_q + 38'(prod);
  assign rnd   = 22'((sum + 38'sd32768) >>> 16);
  assign sat18 = (rnd > 22'sd131071) ? 18'sd131071 :
                 (rnd < -22'sd131072) ? -18'sd131072 : rnd[17:0];

  // Step along local Y, round, saturate the end coordinate
  assign dprod = $signed({1'b0, step_q}) * orient_q[idx_y];
  assign drnd  = 34'((dprod + 50'sd32768) >>> 16);
  assign dend  = 35'(pos_q[step_cnt_q[1:0]]) + 35'(drnd);
  assign sat32 = (dend > 35'sd2147483647) ? 32'sh7FFFFFFF :
                 (dend < -35'sd2147483648) ? 32'sh80000000 : dend[31:0];

  logic full;
  logic seg_match;
  assign full = (CmpW'(cnt_q) >= CmpW'(maxseg_q)) || (cnt_q >= CntW'(SEG_DEPTH));
  assign seg_match = seg_rd_q == {sege_q[2], sege_q[1], sege_q[0],
                                  segs_q[2], segs_q[1], segs_q[0]};

  always_comb begin
    for (int i = 0; i < 9; i++) stk_wdata[i*18 +: 18] = orient_q[i];
    for (int i = 0; i < 3; i++) stk_wdata[162 + i*32 +: 32] = pos_q[i];
  end

  assign s_axis_tready = (state_q == tsg_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    orient_d   = orient_q;
    pos_d      = pos_q;
    segs_d     = segs_q;
    sege_d     = sege_q;
    lvl_d      = lvl_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    cmp_vld_d  = 1'b0;
    sym_d      = sym_q;
    step_cnt_d = step_cnt_q;
    acc_d      = acc_q;
    va_d       = va_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_st_d   = out_st_q;
    out_dat_d  = out_dat_q;
    seg_we     = 1'b0;
    seg_waddr  = cnt_q[SegAw-1:0];
    seg_raddr  = scan_q[SegAw-1:0];
    stk_we     = 1'b0;
    stk_addr   = lvl_q[StkAw-1:0];

    case (state_q)
      tsg_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d = s_axis_tdata;
          if (s_axis_tuser[0]) begin
            // Clear the frame, stack level and segment count
            for (int i = 0; i < 9; i++)
              orient_d[i] = (i % 4 == 0) ? tsg_pkg::OneQ16 : '0;
            for (int i = 0; i < 3; i++) pos_d[i] = '0;
            lvl_d = '0;
            cnt_d = '0;
          end
          state_d = tsg_pkg::S_DECODE;
        end
      end
      tsg_pkg::S_DECODE: begin
        res_d      = tsg_pkg::StTurn;
        step_cnt_d = '0;
        acc_d      = '0;
        state_d    = tsg_pkg::S_EMIT;
        if (full) begin
          res_d = tsg_pkg::StFull;
        end else begin
          case (sym_q)
            tsg_pkg::SymPush: begin
              if (lvl_q >= LvlW'(STACK_DEPTH)) begin
                res_d = tsg_pkg::StOver;
              end else begin
                stk_we = 1'b1;
                lvl_d  = lvl_q + 1'b1;
              end
            end
            tsg_pkg::SymPop: begin
              if (lvl_q == '0) res_d = tsg_pkg::StUnder;
              else begin
                lvl_d   = lvl_q - 1'b1;
                state_d = tsg_pkg::S_POP_RD;
              end
            end
            tsg_pkg::SymPlus, tsg_pkg::SymMinus, tsg_pkg::SymAmp,
            tsg_pkg::SymPct, tsg_pkg::SymHash, tsg_pkg::SymSlash:
              state_d = tsg_pkg::S_TURN;
            default: state_d = tsg_pkg::S_DRAW;
          endcase
        end
      end
      tsg_pkg::S_TURN: begin
        step_cnt_d = step_cnt_q + 1'b1;
        case (phase)
          2'd0: begin
            va_d  = orient_q[idx_a];
            acc_d = 38'(prod);
          end
          2'd1: begin
            orient_d[idx_a] = sat18;
            acc_d = '0;
          end
          2'd2: acc_d = 38'(prod);
          default: begin
            orient_d[idx_b] = sat18;
            acc_d = '0;
            if (row == 2'd2) state_d = tsg_pkg::S_EMIT;
          end
        endcase
      end
      tsg_pkg::S_DRAW: begin
        segs_d[step_cnt_q[1:0]] = pos_q[step_cnt_q[1:0]];
        sege_d[step_cnt_q[1:0]] = sat32;
        step_cnt_d = step_cnt_q + 1'b1;
        scan_d     = '0;
        if (step_cnt_q[1:0] == 2'd2) state_d = tsg_pkg::S_SCAN;
      end
      tsg_pkg::S_SCAN: begin
        // Walk the stored rows; compare each one in the cycle after its read
        if (cmp_vld_q && seg_match) begin
          res_d   = tsg_pkg::StDup;
          pos_d   = sege_q;
          state_d = tsg_pkg::S_EMIT;
        end else if (scan_q < cnt_q) begin
          scan_d    = scan_q + 1'b1;
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          seg_we  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          res_d   = tsg_pkg::StNew;
          pos_d   = sege_q;
          state_d = tsg_pkg::S_EMIT;
        end
      end
      tsg_pkg::S_POP_RD: state_d = tsg_pkg::S_POP_LD;
      tsg_pkg::S_POP_LD: begin
        for (int i = 0; i < 9; i++) orient_d[i] = stk_rd_q[i*18 +: 18];
        for (int i = 0; i < 3; i++) pos_d[i] = stk_rd_q[162 + i*32 +: 32];
        state_d = tsg_pkg::S_EMIT;
      end
      tsg_pkg::S_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_st_d  = res_q;
          out_dat_d = (res_q == tsg_pkg::StNew) ?
                      {sege_q[2], sege_q[1], sege_q[0], segs_q[2], segs_q[1], segs_q[0]} :
                      '0;
          state_d   = tsg_pkg::S_IDLE;
        end
      end
      default: state_d = tsg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tsg_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) orient_q[i] <= (i % 4 == 0) ? tsg_pkg::OneQ16 : '0;
      for (int i = 0; i < 3; i++) pos_q[i] <= '0;
      lvl_q      <= '0;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      step_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      orient_q   <= orient_d;
      pos_q      <= pos_d;
      lvl_q      <= lvl_d;
      cnt_q      <= cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      step_cnt_q <= step_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    segs_q    <= segs_d;
    sege_q    <= sege_d;
    scan_q    <= scan_d;
    sym_q     <= sym_d;
    acc_q     <= acc_d;
    va_q      <= va_d;
    res_q     <= res_d;
    out_st_q  <= out_st_d;
    out_dat_q <= out_dat_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = out_dat_q;

  `TSG_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(SEG_DEPTH))
  `TSG_ASSERT_IMP(a_lvl_bound, clk_i, rst_ni, 1'b1, lvl_q <= LvlW'(STACK_DEPTH))
  `TSG_ASSERT_NXT(a_new_clear, clk_i, rst_ni,
                  s_axis_tvalid && s_axis_tready && s_axis_tuser[0],
                  lvl_q == '0 && cnt_q == '0)
  `TSG_ASSERT_IMP(a_scan_range, clk_i, rst_ni,
                  state_q == tsg_pkg::S_SCAN, scan_q <= cnt_q)

endmodule
